>>> src/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg
// Shared types and constants of the averaged brightness block.
// ----------------------------------------------------------------------------
package abt_pkg;

    localparam int unsigned BRIGHT_W = 8;
    localparam int unsigned WAKE_W   = 12;
    localparam int unsigned IDLE_W   = 10;
    localparam int unsigned CFG_W    = 12;
    localparam int unsigned CIDX_W   = 2;

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    localparam logic [CIDX_W-1:0] REG_OUT_LOW   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_OUT_HIGH  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_WAKE_LVL  = 2'd3;

    localparam logic [BRIGHT_W-1:0] RST_OUT_LOW  = 8'd5;
    localparam logic [BRIGHT_W-1:0] RST_OUT_HIGH = 8'd150;
    localparam logic [IDLE_W-1:0]   RST_TIMEOUT  = 10'd750;
    localparam logic [WAKE_W-1:0]   RST_WAKE_LVL = 12'd4095;

    typedef struct packed {
        logic                shift;
        logic [BRIGHT_W-1:0] data;
    } t_win_in;

endpackage

>>> src/averaged_brightness_with_timeout.sv
// ----------------------------------------------------------------------------
// averaged_brightness_with_timeout
// Scales a level sample, averages it over a window of cells and forces the
// result to zero after a run of ticks without a wake match.
// Throughput: one item per cycle while i_stall does not hold the output; each
// of the four stages moves on its own, and an item passes stages 1 to 4 in order.
// Reset: synchronous, clears the window cells, sum, idle counter and valids,
// and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module averaged_brightness_with_timeout #(
    parameter int unsigned WINDOW      = 100,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [abt_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [abt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [SAMPLE_BITS-1:0]        i_level_sample,
    input  logic [abt_pkg::WAKE_W-1:0]    i_wake_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [abt_pkg::BRIGHT_W-1:0]  o_brightness
);

    localparam int unsigned BW      = abt_pkg::BRIGHT_W;
    localparam int unsigned IW      = abt_pkg::IDLE_W;
    localparam int unsigned PROD_W  = SAMPLE_BITS + BW;
    localparam int unsigned TOTAL_W = $clog2(WINDOW * 255 + 1);
    localparam int unsigned DIV_L   = $clog2(WINDOW);
    localparam int unsigned DIV_S   = TOTAL_W + DIV_L;
    localparam logic [TOTAL_W:0] DIV_M =
        (TOTAL_W+1)'(((64'd1 << DIV_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int unsigned AVG_W   = 2 * TOTAL_W + 1;

    // configuration
    logic [BW-1:0]                  r_out_low;
    logic [BW-1:0]                  r_out_high;
    logic [IW-1:0]                  r_timeout;
    logic [abt_pkg::WAKE_W-1:0]     r_wake_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_low  <= abt_pkg::RST_OUT_LOW;
            r_out_high <= abt_pkg::RST_OUT_HIGH;
            r_timeout  <= abt_pkg::RST_TIMEOUT;
            r_wake_lvl <= abt_pkg::RST_WAKE_LVL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                abt_pkg::REG_OUT_LOW:  r_out_low  <= i_cfg_data[BW-1:0];
                abt_pkg::REG_OUT_HIGH: r_out_high <= i_cfg_data[BW-1:0];
                abt_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_data[IW-1:0];
                abt_pkg::REG_WAKE_LVL: r_wake_lvl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_en2, w_en3, w_en4;

    assign w_rdy4 = !r_v4 || !i_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_en2  = r_v1 && w_rdy2;
    assign w_en3  = r_v2 && w_rdy3;
    assign w_en4  = r_v3 && w_rdy4;
    assign o_stall = !w_rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: span product and wake compare
    logic [BW-1:0]     w_span;
    logic [PROD_W-1:0] r_s1_prod;
    logic              r_s1_wake;

    assign w_span = (r_out_high > r_out_low) ? (r_out_high - r_out_low) : '0;

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy1) begin
            r_s1_prod <= PROD_W'(i_level_sample) * PROD_W'(w_span);
            r_s1_wake <= (i_wake_sample == r_wake_lvl);
        end
    end

    // stage 2: divide by 2^n-1, window update, idle counter
    logic [PROD_W:0]    w_q_sum;
    logic [BW-1:0]      w_scaled;
    abt_pkg::t_win_in   w_win;
    logic [TOTAL_W-1:0] w_total_next;
    logic [IW-1:0]      r_idle;
    logic [IW-1:0]      n_idle;
    logic [IW-1:0]      w_idle_base;
    logic               w_zero;
    logic [TOTAL_W-1:0] r_s2_total;
    logic               r_s2_zero;

    assign w_q_sum  = {1'b0, r_s1_prod} + (PROD_W+1)'(r_s1_prod >> SAMPLE_BITS)
                      + (PROD_W+1)'(1);
    assign w_scaled = r_out_low + BW'(w_q_sum >> SAMPLE_BITS);

    assign w_win.shift = w_en2;
    assign w_win.data  = w_scaled;

    abt_window #(
        .WINDOW  (WINDOW),
        .TOTAL_W (TOTAL_W)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_win        (w_win),
        .o_total_next (w_total_next)
    );

    always_comb begin
        w_idle_base = r_s1_wake ? '0 : r_idle;
        w_zero      = (w_idle_base >= r_timeout);
        if (w_zero) begin
            w_idle_base = r_timeout;
        end
        n_idle = (w_idle_base < abt_pkg::IDLE_MAX) ? w_idle_base + IW'(1) : w_idle_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
        end else if (w_en2) begin
            r_idle <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_total <= w_total_next;
            r_s2_zero  <= w_zero;
        end
    end

    // stage 3: reciprocal multiply for the window average
    logic [AVG_W-1:0] r_s3_prod;
    logic             r_s3_zero;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_prod <= AVG_W'(r_s2_total) * AVG_W'(DIV_M);
            r_s3_zero <= r_s2_zero;
        end
    end

    // stage 4: output register
    logic [BW-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out <= r_s3_zero ? '0 : r_s3_prod[DIV_S +: BW];
        end
    end

    assign o_brightness = r_out;

`ifndef ASSERT_OFF
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en4 && r_s3_zero) |=> (o_brightness == '0))
        else $error("timed-out item not forced to zero");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("input stalled with empty first stage");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en4 |=> o_valid)
        else $error("output stage lost an item");

    a_idle_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en2 && w_zero) |=> (r_idle == $past(n_idle)))
        else $error("idle counter not clamped");
`endif

endmodule

>>> src/abt_cell.sv
// ----------------------------------------------------------------------------
// abt_cell
// One window cell: holds a scaled sample and passes it on at each shift.
// ----------------------------------------------------------------------------
module abt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [abt_pkg::BRIGHT_W-1:0]  i_d,
    output logic [abt_pkg::BRIGHT_W-1:0]  o_q
);

    logic [abt_pkg::BRIGHT_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

>>> src/abt_window.sv
// ----------------------------------------------------------------------------
// abt_window
// Chain of window cells plus the running sum over all cells.
// ----------------------------------------------------------------------------
module abt_window #(
    parameter int unsigned WINDOW  = 100,
    parameter int unsigned TOTAL_W = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  abt_pkg::t_win_in     i_win,
    output logic [TOTAL_W-1:0]   o_total_next
);

    localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(WINDOW * 255);

    logic [abt_pkg::BRIGHT_W-1:0] w_tap [WINDOW+1];
    logic [TOTAL_W-1:0]           r_total;
    logic [TOTAL_W-1:0]           n_total;

    assign w_tap[0] = i_win.data;

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        abt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_win.shift),
            .i_d     (w_tap[k]),
            .o_q     (w_tap[k+1])
        );
    end

    // oldest entry leaves, new one enters
    assign n_total = r_total + TOTAL_W'(i_win.data) - TOTAL_W'(w_tap[WINDOW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_win.shift) begin
            r_total <= n_total;
        end
    end

    assign o_total_next = n_total;

`ifndef ASSERT_OFF
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MAX_TOTAL)
        else $error("window sum out of range");

    a_total_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_win.shift && i_win.data == w_tap[WINDOW]) |=> $stable(r_total))
        else $error("window sum moved on equal swap");

    a_total_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_total == '0))
        else $error("window sum not cleared");
`endif

endmodule
